>>> rtl/spring_damper_edge_force_unit_defines.svh
`ifndef SPRING_DAMPER_EDGE_FORCE_UNIT_DEFINES_SVH
`define SPRING_DAMPER_EDGE_FORCE_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define SDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge force check failed");

// Check a consequence in the cycle after its cause
`define SDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge force check failed");

`endif

>>> rtl/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

    // Field widths
    localparam int IN_W      = 32;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int AXES      = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NATURAL_LENGTH = 2'd2;

    localparam logic [CFG_W-1:0] STIFFNESS_RST      = 32'h0001_0000;
    localparam logic [CFG_W-1:0] DAMPING_RST        = 32'h0000_0000;
    localparam logic [CFG_W-1:0] NATURAL_LENGTH_RST = 32'h0000_0000;

    // Datapath widths
    localparam int D_W    = IN_W + 1;      // coordinate difference, signed
    localparam int DMAG_W = D_W;           // its magnitude
    localparam int SQ_W   = 2 * DMAG_W;    // one square or product
    localparam int S_W    = SQ_W;          // sum of three squares
    localparam int PN_W   = SQ_W + 2;      // sum of three products
    localparam int ROOT_W = 33;            // integer square root of S
    localparam int SQT_W  = S_W + 2;       // square-root residual and trial
    localparam int DIFF_W = ROOT_W + 1;    // length minus rest length, signed

    // Multiplier: 102 x 34 as three 34 x 34 partial products
    localparam int MUL_CH     = 34;
    localparam int MUL_A_W    = 3 * MUL_CH;
    localparam int MUL_B_W    = MUL_CH;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_STAGES = 3;

    // Divider: quotient of 33 bits plus overflow
    localparam int DVD_W      = 116;
    localparam int DVS_W      = S_W;
    localparam int Q_W        = 33;
    localparam int DIV_STAGES = Q_W + 1;

    localparam int SPRING_SHIFT = 16;
    localparam int DAMP_SHIFT   = 17;

    localparam int FRONT_STAGES = 3;
    localparam int SIDE_DEPTH   = 2 * MUL_STAGES + 1;
    localparam int PIPE_DEPTH   = FRONT_STAGES + ROOT_W + SIDE_DEPTH + DIV_STAGES + 1;

    localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'(64'h7FFF_FFFF);
    localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(64'h8000_0000);

    // Per-edge data carried alongside the square root
    typedef struct packed {
        logic [AXES-1:0][DMAG_W-1:0] dmag;
        logic [AXES-1:0]             dneg;
        logic [S_W-1:0]              s;
        logic [PN_W-1:0]             pos;
        logic [PN_W-1:0]             neg;
    } edge_info_t;

    // Result signs and the coincident-node flag
    typedef struct packed {
        logic [AXES-1:0] nsp;
        logic [AXES-1:0] ndp;
        logic            zero;
    } flags_t;

    // Data carried alongside the multipliers
    typedef struct packed {
        logic [AXES-1:0][DMAG_W-1:0] dmag;
        logic [ROOT_W-1:0]           len;
        logic [S_W-1:0]              s;
        flags_t                      f;
    } side_t;

    // Saturate a truncated magnitude with its sign to 32 bits
    function automatic logic [OUT_W-1:0] sat_q(input logic neg, input logic ovf,
                                               input logic [Q_W-1:0] q);
        logic [Q_W-1:0] nq;
        nq = Q_W'(0) - q;
        if (neg) begin
            if (ovf || q > Q_NEG_LIM) begin
                return OUT_W'(Q_NEG_LIM);
            end
            return nq[OUT_W-1:0];
        end
        if (ovf || q > Q_POS_LIM) begin
            return OUT_W'(Q_POS_LIM);
        end
        return q[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/sdf_if.sv
`default_nettype none

interface sdf_edge_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;

    modport source (
        output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
               vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
        input  ready
    );
    modport sink (
        input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
               vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
        output ready
    );
endinterface

interface sdf_force_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] spring_a_x;
    logic signed [31:0] spring_a_y;
    logic signed [31:0] spring_a_z;
    logic signed [31:0] spring_b_x;
    logic signed [31:0] spring_b_y;
    logic signed [31:0] spring_b_z;
    logic signed [31:0] damp_a_x;
    logic signed [31:0] damp_a_y;
    logic signed [31:0] damp_a_z;
    logic signed [31:0] damp_b_x;
    logic signed [31:0] damp_b_y;
    logic signed [31:0] damp_b_z;

    modport source (
        output valid, spring_a_x, spring_a_y, spring_a_z, spring_b_x, spring_b_y,
               spring_b_z, damp_a_x, damp_a_y, damp_a_z, damp_b_x, damp_b_y, damp_b_z,
        input  ready
    );
    modport sink (
        input  valid, spring_a_x, spring_a_y, spring_a_z, spring_b_x, spring_b_y,
               spring_b_z, damp_a_x, damp_a_y, damp_a_z, damp_b_x, damp_b_y, damp_b_z,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/sdf_mul.sv
`default_nettype none

module sdf_mul (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [sdf_pkg::MUL_A_W-1:0]  a,
    input  wire logic [sdf_pkg::MUL_B_W-1:0]  b,
    output logic      [sdf_pkg::MUL_P_W-1:0]  p
);
    import sdf_pkg::*;

    localparam int PP_W = 2 * MUL_CH;

    logic [PP_W-1:0]    pp0_reg;
    logic [PP_W-1:0]    pp1_reg;
    logic [PP_W-1:0]    pp2_reg;
    logic [PP_W-1:0]    pp2_d_reg;
    logic [MUL_P_W-1:0] sum01_reg;
    logic [MUL_P_W-1:0] p_reg;

    // Form the partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp0_reg <= PP_W'(a[0*MUL_CH +: MUL_CH]) * PP_W'(b);
            pp1_reg <= PP_W'(a[1*MUL_CH +: MUL_CH]) * PP_W'(b);
            pp2_reg <= PP_W'(a[2*MUL_CH +: MUL_CH]) * PP_W'(b);
        end
    end

    // Add the lower two, then the top one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum01_reg <= MUL_P_W'(pp0_reg) + (MUL_P_W'(pp1_reg) << MUL_CH);
            pp2_d_reg <= pp2_reg;
            p_reg     <= sum01_reg + (MUL_P_W'(pp2_d_reg) << (2 * MUL_CH));
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/sdf_sqrt.sv
`default_nettype none

module sdf_sqrt (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [sdf_pkg::S_W-1:0]     s_in,
    input  var  sdf_pkg::edge_info_t         info_in,
    output logic      [sdf_pkg::ROOT_W-1:0]  root_out,
    output sdf_pkg::edge_info_t              info_out
);
    import sdf_pkg::*;

    logic [SQT_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    edge_info_t        info_reg [ROOT_W];

    // One root bit per stage, most significant first
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam int B = ROOT_W - 1 - k;
        logic [SQT_W-1:0]  rem_c;
        logic [ROOT_W-1:0] root_c;
        edge_info_t        info_c;
        logic [SQT_W-1:0]  trial;

        if (k == 0)
        begin : g_first
            assign rem_c  = SQT_W'(s_in);
            assign root_c = '0;
            assign info_c = info_in;
        end
        else
        begin : g_next
            assign rem_c  = rem_reg[k-1];
            assign root_c = root_reg[k-1];
            assign info_c = info_reg[k-1];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
        assign trial = (SQT_W'(root_c) << (B + 1)) | (SQT_W'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_c >= trial)
                begin
                    rem_reg[k]  <= rem_c - trial;
                    root_reg[k] <= root_c | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[k]  <= rem_c;
                    root_reg[k] <= root_c;
                end
                info_reg[k] <= info_c;
            end
        end
    end

    assign root_out = root_reg[ROOT_W-1];
    assign info_out = info_reg[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/sdf_div.sv
`default_nettype none

module sdf_div (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [sdf_pkg::DVD_W-1:0]  dvd,
    input  wire logic [sdf_pkg::DVS_W-1:0]  dvs,
    output logic      [sdf_pkg::Q_W-1:0]    quo,
    output logic                            ovf
);
    import sdf_pkg::*;

    logic             ovf0_reg;
    logic [DVS_W-1:0] rem0_reg;
    logic [Q_W-1:0]   low0_reg;
    logic [DVS_W-1:0] dvs0_reg;

    logic             ovf_reg [Q_W];
    logic [DVS_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [DVS_W-1:0] dvs_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    logic             ovf0_next;

    // Flag quotients of 2^Q_W or more; otherwise the top part is the first remainder
    assign ovf0_next = dvd[DVD_W-1:Q_W] >= (DVD_W-Q_W)'(dvs);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf0_reg <= ovf0_next;
            rem0_reg <= ovf0_next ? '0 : DVS_W'(dvd[DVD_W-1:Q_W]);
            low0_reg <= dvd[Q_W-1:0];
            dvs0_reg <= dvs;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        localparam int B = Q_W - 1 - k;
        logic             ovf_c;
        logic [DVS_W-1:0] rem_c;
        logic [Q_W-1:0]   low_c;
        logic [DVS_W-1:0] dvs_c;
        logic [Q_W-1:0]   q_c;
        logic [DVS_W:0]   t;

        if (k == 0)
        begin : g_first
            assign ovf_c = ovf0_reg;
            assign rem_c = rem0_reg;
            assign low_c = low0_reg;
            assign dvs_c = dvs0_reg;
            assign q_c   = '0;
        end
        else
        begin : g_next
            assign ovf_c = ovf_reg[k-1];
            assign rem_c = rem_reg[k-1];
            assign low_c = low_reg[k-1];
            assign dvs_c = dvs_reg[k-1];
            assign q_c   = q_reg[k-1];
        end

        assign t = {rem_c, low_c[B]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (t >= {1'b0, dvs_c})
                begin
                    rem_reg[k] <= DVS_W'(t - {1'b0, dvs_c});
                    q_reg[k]   <= q_c | (Q_W'(1) << B);
                end
                else
                begin
                    rem_reg[k] <= DVS_W'(t);
                    q_reg[k]   <= q_c;
                end
                ovf_reg[k] <= ovf_c;
                low_reg[k] <= low_c;
                dvs_reg[k] <= dvs_c;
            end
        end
    end

    assign quo = q_reg[Q_W-1];
    assign ovf = ovf_reg[Q_W-1];

endmodule

`default_nettype wire

>>> rtl/spring_damper_edge_force_unit.sv
// Spring-damper force of one 3D edge per item, signed Q16.16 throughout.
// Input channel edges: positions and velocities of nodes a and b. Output
// channel forces: spring and damping vectors on node a and their negations
// on node b, each saturated to 32 bits. Both channels move an item on a
// rising edge with valid and ready high.
// Configuration: cfg_we, cfg_index, cfg_wdata write stiffness (0), damping (1)
// and natural length (2); other indexes are ignored. Write only while idle.
// The path is three front stages, a 33-stage square root, one length-error
// stage, two 3-stage multipliers and a 34-stage restoring divider per axis,
// then the output register.
// Throughput: one item per cycle while the output is not stalled; every
// stage is one step of its unit.
// Reset clears the valid bits and loads the register defaults (stiffness
// 1.0, damping 0, natural length 0). When the receiver stalls the whole
// pipeline holds and edges.ready falls while the output register is full;
// it stays high while the output register is empty or being taken.
// Coincident nodes give zero forces on both nodes.
`default_nettype none

module spring_damper_edge_force_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    sdf_edge_if.sink                           edges,
    sdf_force_if.source                        forces,
    input  wire logic                          cfg_we,
    input  wire logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sdf_pkg::CFG_W-1:0]     cfg_wdata
);
    import sdf_pkg::*;

    `include "spring_damper_edge_force_unit_defines.svh"

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;

    logic [CFG_W-1:0] stiffness_reg;
    logic [CFG_W-1:0] damping_reg;
    logic [CFG_W-1:0] nat_len_reg;

    logic signed [IN_W-1:0] pa [AXES];
    logic signed [IN_W-1:0] pb [AXES];
    logic signed [IN_W-1:0] va [AXES];
    logic signed [IN_W-1:0] vb [AXES];

    logic signed [D_W-1:0] d_reg  [AXES];
    logic signed [D_W-1:0] rv_reg [AXES];

    logic [DMAG_W-1:0] dmag_c [AXES];
    logic [DMAG_W-1:0] rvmag_c [AXES];
    logic [DMAG_W-1:0] dmag_b_reg [AXES];
    logic              dneg_b_reg [AXES];
    logic [SQ_W-1:0]   sq_b_reg   [AXES];
    logic [SQ_W-1:0]   prv_b_reg  [AXES];
    logic              pneg_b_reg [AXES];

    logic [S_W-1:0]  s_next;
    logic [PN_W-1:0] pos_next;
    logic [PN_W-1:0] neg_next;
    logic [S_W-1:0]  s_c_reg;
    edge_info_t      info_c_reg;
    edge_info_t      info_c_next;

    logic [ROOT_W-1:0] root_q;
    edge_info_t        info_q;

    logic [DIFF_W-1:0] diff;
    logic              negd;
    logic              negp;
    logic [PN_W-1:0]   pm;
    logic [DMAG_W-1:0] dfmag_reg;
    logic [PN_W-1:0]   pm_reg;
    side_t             side_next;
    side_t             side_reg [SIDE_DEPTH];
    flags_t            flag_reg [DIV_STAGES];

    logic [MUL_P_W-1:0] p1_spring;
    logic [MUL_P_W-1:0] p1_damp;
    logic [MUL_P_W-1:0] p2_spring [AXES];
    logic [MUL_P_W-1:0] p2_damp   [AXES];
    logic [Q_W-1:0]     sq_quo [AXES];
    logic               sq_ovf [AXES];
    logic [Q_W-1:0]     dq_quo [AXES];
    logic               dq_ovf [AXES];

    logic [OUT_W-1:0] spa_next [AXES];
    logic [OUT_W-1:0] spb_next [AXES];
    logic [OUT_W-1:0] dpa_next [AXES];
    logic [OUT_W-1:0] dpb_next [AXES];
    logic [OUT_W-1:0] spa_reg  [AXES];
    logic [OUT_W-1:0] spb_reg  [AXES];
    logic [OUT_W-1:0] dpa_reg  [AXES];
    logic [OUT_W-1:0] dpb_reg  [AXES];

    // Advance the whole pipeline unless a finished item is stuck at the output
    assign adv          = !vld_reg[PIPE_DEPTH-1] || forces.ready;
    assign edges.ready  = adv;
    assign forces.valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], edges.valid};
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= STIFFNESS_RST;
            damping_reg   <= DAMPING_RST;
            nat_len_reg   <= NATURAL_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STIFFNESS:      stiffness_reg <= cfg_wdata;
                REG_DAMPING:        damping_reg   <= cfg_wdata;
                REG_NATURAL_LENGTH: nat_len_reg   <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    assign pa[0] = edges.pos_a_x;
    assign pa[1] = edges.pos_a_y;
    assign pa[2] = edges.pos_a_z;
    assign pb[0] = edges.pos_b_x;
    assign pb[1] = edges.pos_b_y;
    assign pb[2] = edges.pos_b_z;
    assign va[0] = edges.vel_a_x;
    assign va[1] = edges.vel_a_y;
    assign va[2] = edges.vel_a_z;
    assign vb[0] = edges.vel_b_x;
    assign vb[1] = edges.vel_b_y;
    assign vb[2] = edges.vel_b_z;

    // Stage A: differences of positions and velocities
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                d_reg[i]  <= D_W'(pb[i]) - D_W'(pa[i]);
                rv_reg[i] <= D_W'(vb[i]) - D_W'(va[i]);
            end
        end
    end

    // Stage B: magnitudes, squares and velocity products
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            dmag_c[i]  = d_reg[i][D_W-1]  ? DMAG_W'(-d_reg[i])  : DMAG_W'(d_reg[i]);
            rvmag_c[i] = rv_reg[i][D_W-1] ? DMAG_W'(-rv_reg[i]) : DMAG_W'(rv_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                dmag_b_reg[i] <= dmag_c[i];
                dneg_b_reg[i] <= d_reg[i][D_W-1];
                sq_b_reg[i]   <= SQ_W'(dmag_c[i]) * SQ_W'(dmag_c[i]);
                prv_b_reg[i]  <= SQ_W'(rvmag_c[i]) * SQ_W'(dmag_c[i]);
                pneg_b_reg[i] <= rv_reg[i][D_W-1] ^ d_reg[i][D_W-1];
            end
        end
    end

    // Stage C: squared length and the split dot product
    always_comb
    begin
        s_next   = '0;
        pos_next = '0;
        neg_next = '0;
        for (int i = 0; i < AXES; i++)
        begin
            s_next = s_next + sq_b_reg[i];
            if (pneg_b_reg[i])
            begin
                neg_next = neg_next + PN_W'(prv_b_reg[i]);
            end
            else
            begin
                pos_next = pos_next + PN_W'(prv_b_reg[i]);
            end
        end
        for (int i = 0; i < AXES; i++)
        begin
            info_c_next.dmag[i] = dmag_b_reg[i];
            info_c_next.dneg[i] = dneg_b_reg[i];
        end
        info_c_next.s   = s_next;
        info_c_next.pos = pos_next;
        info_c_next.neg = neg_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_c_reg    <= s_next;
            info_c_reg <= info_c_next;
        end
    end

    sdf_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .s_in     (s_c_reg),
        .info_in  (info_c_reg),
        .root_out (root_q),
        .info_out (info_q)
    );

    // Stage E: length error, net dot product and result signs
    always_comb
    begin
        diff = {1'b0, root_q} - DIFF_W'(nat_len_reg);
        negd = diff[DIFF_W-1];
        if (info_q.pos >= info_q.neg)
        begin
            pm   = info_q.pos - info_q.neg;
            negp = 1'b0;
        end
        else
        begin
            pm   = info_q.neg - info_q.pos;
            negp = 1'b1;
        end
        side_next.dmag   = info_q.dmag;
        side_next.len    = root_q;
        side_next.s      = info_q.s;
        side_next.f.zero = (info_q.s == '0);
        for (int i = 0; i < AXES; i++)
        begin
            side_next.f.nsp[i] = negd ^ info_q.dneg[i];
            side_next.f.ndp[i] = negp ^ info_q.dneg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dfmag_reg   <= negd ? DMAG_W'(-diff) : DMAG_W'(diff);
            pm_reg      <= pm;
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Coefficient times length error, and times net dot product
    sdf_mul u_mul_spring (
        .clk (clk),
        .en  (adv),
        .a   (MUL_A_W'(dfmag_reg)),
        .b   (MUL_B_W'(stiffness_reg)),
        .p   (p1_spring)
    );

    sdf_mul u_mul_damp (
        .clk (clk),
        .en  (adv),
        .a   (MUL_A_W'(pm_reg)),
        .b   (MUL_B_W'(damping_reg)),
        .p   (p1_damp)
    );

    // Per axis: scale by |d|, then divide by L * 2^16 and by S * 2^17
    for (genvar i = 0; i < AXES; i++)
    begin : g_axis
        sdf_mul u_mul2_spring (
            .clk (clk),
            .en  (adv),
            .a   (p1_spring[MUL_A_W-1:0]),
            .b   (MUL_B_W'(side_reg[MUL_STAGES].dmag[i])),
            .p   (p2_spring[i])
        );

        sdf_mul u_mul2_damp (
            .clk (clk),
            .en  (adv),
            .a   (p1_damp[MUL_A_W-1:0]),
            .b   (MUL_B_W'(side_reg[MUL_STAGES].dmag[i])),
            .p   (p2_damp[i])
        );

        sdf_div u_div_spring (
            .clk (clk),
            .en  (adv),
            .dvd (p2_spring[i][DVD_W+SPRING_SHIFT-1:SPRING_SHIFT]),
            .dvs (DVS_W'(side_reg[SIDE_DEPTH-1].len)),
            .quo (sq_quo[i]),
            .ovf (sq_ovf[i])
        );

        sdf_div u_div_damp (
            .clk (clk),
            .en  (adv),
            .dvd (p2_damp[i][DVD_W+DAMP_SHIFT-1:DAMP_SHIFT]),
            .dvs (side_reg[SIDE_DEPTH-1].s),
            .quo (dq_quo[i]),
            .ovf (dq_ovf[i])
        );
    end

    // Carry signs and the coincident flag beside the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flag_reg[0] <= side_reg[SIDE_DEPTH-1].f;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    // Output stage: sign, saturate, and zero coincident nodes
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (flag_reg[DIV_STAGES-1].zero)
            begin
                spa_next[i] = '0;
                spb_next[i] = '0;
                dpa_next[i] = '0;
                dpb_next[i] = '0;
            end
            else
            begin
                spa_next[i] = sat_q(flag_reg[DIV_STAGES-1].nsp[i], sq_ovf[i], sq_quo[i]);
                spb_next[i] = sat_q(!flag_reg[DIV_STAGES-1].nsp[i], sq_ovf[i], sq_quo[i]);
                dpa_next[i] = sat_q(flag_reg[DIV_STAGES-1].ndp[i], dq_ovf[i], dq_quo[i]);
                dpb_next[i] = sat_q(!flag_reg[DIV_STAGES-1].ndp[i], dq_ovf[i], dq_quo[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            spa_reg <= spa_next;
            spb_reg <= spb_next;
            dpa_reg <= dpa_next;
            dpb_reg <= dpb_next;
        end
    end

    assign forces.spring_a_x = spa_reg[0];
    assign forces.spring_a_y = spa_reg[1];
    assign forces.spring_a_z = spa_reg[2];
    assign forces.spring_b_x = spb_reg[0];
    assign forces.spring_b_y = spb_reg[1];
    assign forces.spring_b_z = spb_reg[2];
    assign forces.damp_a_x   = dpa_reg[0];
    assign forces.damp_a_y   = dpa_reg[1];
    assign forces.damp_a_z   = dpa_reg[2];
    assign forces.damp_b_x   = dpb_reg[0];
    assign forces.damp_b_y   = dpb_reg[1];
    assign forces.damp_b_z   = dpb_reg[2];

    // Node b mirrors node a wherever node a is off the limits (spring x, damping y)
    `SDF_ASSERT_SAME(a_spring_mirror, forces.valid && forces.spring_a_x != 32'sh7FFFFFFF && forces.spring_a_x != 32'sh80000000, forces.spring_b_x == -forces.spring_a_x)
    `SDF_ASSERT_SAME(a_damp_mirror, forces.valid && forces.damp_a_y != 32'sh7FFFFFFF && forces.damp_a_y != 32'sh80000000, forces.damp_b_y == -forces.damp_a_y)
    // A stalled output freezes every valid bit in the pipeline
    `SDF_ASSERT_NEXT(a_stall_freeze, vld_reg[PIPE_DEPTH-1] && !forces.ready, $stable(vld_reg))

endmodule

`default_nettype wire

>>> bench/spring_damper_edge_force_unit_tb.sv
`timescale 1ns / 1ps

module spring_damper_edge_force_unit_tb;
    import sdf_pkg::*;

    // Edge item: pos_a xyz, pos_b xyz, vel_a xyz, vel_b xyz
    typedef logic [11:0][31:0] edge_vec_t;
    // Force item: spring_a xyz, spring_b xyz, damp_a xyz, damp_b xyz
    typedef logic [11:0][31:0] force_vec_t;

    // Predicts forces per edge and holds them until they come out
    class force_scoreboard;
        force_vec_t  expected_forces[$];
        logic [31:0] stiffness;
        logic [31:0] damping;
        logic [31:0] natural_length;
        int          errors;

        function new();
            stiffness      = STIFFNESS_RST;
            damping        = DAMPING_RST;
            natural_length = NATURAL_LENGTH_RST;
            errors         = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_STIFFNESS:      stiffness = value;
                REG_DAMPING:        damping = value;
                REG_NATURAL_LENGTH: natural_length = value;
                default: ;
            endcase
        endfunction

        // Saturate a truncated magnitude with its sign
        function logic [31:0] saturate(bit neg, logic [255:0] q);
            if (neg) begin
                if (q > 256'h8000_0000) return 32'h8000_0000;
                return 32'h0 - q[31:0];
            end
            if (q > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
            return q[31:0];
        endfunction

        function force_vec_t edge_forces(edge_vec_t e);
            logic signed [33:0] d[3];
            logic signed [33:0] rv[3];
            logic [33:0]        dabs[3];
            logic [33:0]        rabs[3];
            logic [255:0]       dm[3];
            logic [255:0]       rm[3];
            logic [255:0]       s, c, len, den, num, q, pos, neg, pm, dfm;
            logic signed [36:0] diff;
            force_vec_t         r;
            bit                 nd, n, np;
            r = '0;
            s = '0;
            for (int i = 0; i < 3; i++) begin
                d[i]  = {{2{e[3+i][31]}}, e[3+i]} - {{2{e[i][31]}}, e[i]};
                rv[i] = {{2{e[9+i][31]}}, e[9+i]} - {{2{e[6+i][31]}}, e[6+i]};
                dabs[i] = d[i] < 0 ? -d[i] : d[i];
                rabs[i] = rv[i] < 0 ? -rv[i] : rv[i];
                dm[i] = {222'b0, dabs[i]};
                rm[i] = {222'b0, rabs[i]};
                s = s + dm[i] * dm[i];
            end
            // Coincident nodes: no force at all
            if (s == 0) return r;
            len = '0;
            for (int b = 34; b >= 0; b--) begin
                c = len | (256'd1 << b);
                if (c * c <= s) len = c;
            end
            // Spring
            diff = $signed({2'b0, len[34:0]}) - $signed({5'b0, natural_length});
            nd   = diff < 0;
            dfm  = nd ? {219'b0, -diff} : {219'b0, diff};
            den  = len * 256'd65536;
            for (int i = 0; i < 3; i++) begin
                num = {224'b0, stiffness} * dfm * dm[i];
                q   = num / den;
                n   = nd != (d[i] < 0);
                r[i]   = saturate(n, q);
                r[3+i] = saturate(!n, q);
            end
            // Damping: projection of relative velocity onto d
            pos = '0;
            neg = '0;
            for (int i = 0; i < 3; i++) begin
                if ((rv[i] < 0) != (d[i] < 0)) neg = neg + rm[i] * dm[i];
                else pos = pos + rm[i] * dm[i];
            end
            np  = pos < neg;
            pm  = np ? neg - pos : pos - neg;
            den = s * 256'd131072;
            for (int i = 0; i < 3; i++) begin
                num = pm * {224'b0, damping} * dm[i];
                q   = num / den;
                n   = np != (d[i] < 0);
                r[6+i] = saturate(n, q);
                r[9+i] = saturate(!n, q);
            end
            return r;
        endfunction

        function void note_edge(edge_vec_t e);
            expected_forces.push_back(edge_forces(e));
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_forces(force_vec_t got);
            force_vec_t exp_f;
            if (expected_forces.size() == 0) begin
                report("force item with none expected");
                return;
            end
            exp_f = expected_forces.pop_front();
            for (int i = 0; i < 12; i++) begin
                if (got[i] !== exp_f[i])
                    report($sformatf("field %0d got %h expected %h", i, got[i], exp_f[i]));
            end
        endtask

        function int pending();
            return expected_forces.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    sdf_edge_if  edges();
    sdf_force_if forces();

    spring_damper_edge_force_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .edges     (edges),
        .forces    (forces),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    force_scoreboard sb = new();
    int send_idle;
    int recv_idle;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check each taken force item and choose the next ready
    always @(posedge clk)
    begin
        if (rst_n && forces.valid && forces.ready) begin
            sb.check_forces({forces.damp_b_z, forces.damp_b_y, forces.damp_b_x,
                             forces.damp_a_z, forces.damp_a_y, forces.damp_a_x,
                             forces.spring_b_z, forces.spring_b_y, forces.spring_b_x,
                             forces.spring_a_z, forces.spring_a_y, forces.spring_a_x});
        end
        forces.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Offer one edge, honouring the sender idle rate
    task automatic send_edge(edge_vec_t e);
        while ($urandom_range(0, 99) < send_idle) begin
            edges.valid <= 1'b0;
            @(posedge clk);
        end
        edges.valid   <= 1'b1;
        edges.pos_a_x <= e[0];
        edges.pos_a_y <= e[1];
        edges.pos_a_z <= e[2];
        edges.pos_b_x <= e[3];
        edges.pos_b_y <= e[4];
        edges.pos_b_z <= e[5];
        edges.vel_a_x <= e[6];
        edges.vel_a_y <= e[7];
        edges.vel_a_z <= e[8];
        edges.vel_b_x <= e[9];
        edges.vel_b_y <= e[10];
        edges.vel_b_z <= e[11];
        do @(posedge clk); while (!edges.ready);
        sb.note_edge(e);
    endtask

    // Drop valid and hold until every expected force item has come
    task automatic drain();
        edges.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    // Write all three registers back to back, then a junk index
    task automatic write_regs(logic [31:0] k, logic [31:0] c, logic [31:0] rest);
        logic [31:0] vals[4];
        vals = '{k, c, rest, $urandom()};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] moderate(int bits);
        return 32'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    function automatic edge_vec_t random_edge();
        edge_vec_t e;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) e[i] = $urandom();
        if (kind >= 2) begin
            for (int i = 0; i < 3; i++) begin
                if (kind >= 5) e[i] = moderate(24);
                e[3+i] = e[i] + moderate($urandom_range(4, 24));
                e[6+i] = moderate(20);
                e[9+i] = moderate(20);
            end
        end
        if (kind == 8) for (int i = 0; i < 3; i++) e[3+i] = e[i];
        if (kind == 9) begin
            e[4] = e[1];
            e[5] = e[2];
        end
        return e;
    endfunction

    function automatic edge_vec_t uniform_edge(logic [31:0] pa, logic [31:0] pb,
                                               logic [31:0] va, logic [31:0] vb);
        edge_vec_t e;
        for (int i = 0; i < 3; i++) begin
            e[i] = pa;
            e[3+i] = pb;
            e[6+i] = va;
            e[9+i] = vb;
        end
        return e;
    endfunction

    task automatic directed_edges();
        edge_vec_t e;
        send_edge('0);
        send_edge(uniform_edge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_edge(uniform_edge(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_edge(uniform_edge(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_edge(uniform_edge(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000));
        send_edge(uniform_edge(32'h0, 32'h0000_0001, 32'h0, 32'h0000_0001));
        send_edge(uniform_edge(32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0));
        send_edge(uniform_edge(32'h0, 32'h0100_0000, 32'h0, 32'h0100_0000));
        send_edge(uniform_edge(32'h0, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000));
        // Unit offset along each axis alone, velocity along and across
        for (int a = 0; a < 3; a++) begin
            e = '0;
            e[3+a] = 32'h0001_0000;
            e[9+a] = 32'h0003_0000;
            e[9+((a+1)%3)] = 32'hFFFD_0000;
            send_edge(e);
            e[3+a] = 32'hFFFF_0000;
            send_edge(e);
        end
        e = '0;
        e[3] = 32'h0003_0000;
        e[4] = 32'hFFFC_0000;
        e[6] = 32'h7FFF_FFFF;
        e[10] = 32'h8000_0000;
        send_edge(e);
        e = '0;
        e[4] = 32'h0000_0003;
        e[5] = 32'h0000_0004;
        send_edge(e);
    endtask

    initial
    begin
        logic [31:0] ks[6];
        logic [31:0] cs[6];
        logic [31:0] ls[6];
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        edges.valid  <= 1'b0;
        {edges.pos_a_x, edges.pos_a_y, edges.pos_a_z} <= '0;
        {edges.pos_b_x, edges.pos_b_y, edges.pos_b_z} <= '0;
        {edges.vel_a_x, edges.vel_a_y, edges.vel_a_z} <= '0;
        {edges.vel_b_x, edges.vel_b_y, edges.vel_b_z} <= '0;
        send_idle = 19;
        recv_idle = 81;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first, then a moderate set with damping
        directed_edges();
        drain();
        write_regs(32'h0002_0000, 32'h0003_0000, 32'h0003_0000);
        directed_edges();
        drain();

        ks = '{32'h0, 32'hFFFF_FFFF, $urandom(), 32'h0001_8000, 32'h0000_0001, $urandom()};
        cs = '{32'h0, 32'hFFFF_FFFF, $urandom(), 32'h0000_4000, 32'hFFFF_FFFF, $urandom()};
        ls = '{32'h0, 32'hFFFF_FFFF, $urandom(), 32'h0010_0000, 32'h0, 32'h0000_0001};
        for (int p = 0; p < 6; p++) begin
            write_regs(ks[p], cs[p], ls[p]);
            send_idle = (p % 3 == 0) ? 19 : (p % 3 == 1) ? 81 : 0;
            recv_idle = (p % 3 == 0) ? 81 : (p % 3 == 1) ? 19 : 0;
            for (int n = 0; n < 230; n++) begin
                // Hold off once until the pipeline has emptied
                if (p == 2 && n == 100) drain();
                send_edge(random_edge());
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
